/* rtl/core/lfs_pkg.sv */
// Shared types and constants of the line follower PD steering block.
`default_nettype none

package lfs_pkg;

    // Width of the shared adder and of the wide working registers.
    localparam int unsigned ALU_W      = 64;
    // Dividend width of the restoring divider (|sum| and time both fit).
    localparam int unsigned DIV_W      = 18;
    // Widest multiplier operand (the derivative term).
    localparam int unsigned MPLIER_W   = 26;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FRAC_BITS  = 24;

    localparam logic [MPLIER_W-1:0] D_COEF_NEWER = MPLIER_W'(100);
    localparam logic [MPLIER_W-1:0] D_COEF_OLDER = MPLIER_W'(210);
    localparam logic signed [8:0]   SPEED_MAX    = 9'sd255;
    localparam logic signed [8:0]   SPEED_MIN    = -9'sd255;

    localparam logic CMD_TIME  = 1'b0;
    localparam logic CMD_SPEED = 1'b1;

    typedef enum logic [2:0] {
        REG_WEIGHT_0   = 3'd0,
        REG_WEIGHT_1   = 3'd1,
        REG_WEIGHT_2   = 3'd2,
        REG_WEIGHT_3   = 3'd3,
        REG_WEIGHT_4   = 3'd4,
        REG_GAIN_PROP  = 3'd5,
        REG_GAIN_DERIV = 3'd6,
        REG_PERIOD     = 3'd7
    } lfs_reg_idx_t;

    localparam logic [15:0] RST_WEIGHT_0   = 16'hFE00;
    localparam logic [15:0] RST_WEIGHT_1   = 16'hFF00;
    localparam logic [15:0] RST_WEIGHT_2   = 16'h0000;
    localparam logic [15:0] RST_WEIGHT_3   = 16'h0100;
    localparam logic [15:0] RST_WEIGHT_4   = 16'h0200;
    localparam logic [23:0] RST_GAIN_PROP  = 24'd65536;
    localparam logic [23:0] RST_GAIN_DERIV = 24'd0;
    localparam logic [16:0] RST_PERIOD     = 17'd10000;

    typedef struct packed {
        logic [4:0][15:0] weight;
        logic [23:0]      gain_prop;
        logic [23:0]      gain_deriv;
        logic [16:0]      period;
    } lfs_cfg_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } lfs_alu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_TADD,
        ST_TFIN,
        ST_X,
        ST_Y,
        ST_D,
        ST_P,
        ST_R,
        ST_MUL,
        ST_OFS,
        ST_OUT
    } lfs_state_t;

    typedef enum logic {
        DIV_ERR,
        DIV_TIME
    } lfs_div_ph_t;

    typedef enum logic [2:0] {
        MUL_X,
        MUL_Y,
        MUL_D,
        MUL_P,
        MUL_R
    } lfs_mul_ph_t;

endpackage

`default_nettype wire

/* rtl/core/lfs_if.sv */
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface lfs_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  sensors;
    logic [15:0] elapsed_us;
    logic [7:0]  max_speed;

    modport source (output valid, command, sensors, elapsed_us, max_speed, input ready);
    modport sink   (input valid, command, sensors, elapsed_us, max_speed, output ready);
endinterface

interface lfs_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] error_value;
    logic [2:0]         detection_count;
    logic [1:0]         blob_count;
    logic signed [8:0]  left_speed;
    logic signed [8:0]  right_speed;
    logic               left_reverse;
    logic [7:0]         left_duty;
    logic               right_reverse;
    logic [7:0]         right_duty;

    modport source (output valid, error_value, detection_count, blob_count, left_speed,
                    right_speed, left_reverse, left_duty, right_reverse, right_duty,
                    input ready);
    modport sink   (input valid, error_value, detection_count, blob_count, left_speed,
                    right_speed, left_reverse, left_duty, right_reverse, right_duty,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/lfs_alu.sv */
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
`default_nettype none

module lfs_alu
    import lfs_pkg::*;
(
    input  lfs_alu_req_t     req,
    output logic [ALU_W-1:0] y
);

    logic [ALU_W-1:0] b_inv;

    assign b_inv = req.sub ? ~req.b : req.b;
    assign y     = req.a + b_inv + ALU_W'(req.sub);

endmodule

`default_nettype wire

/* rtl/core/lfs_regs.sv */
// Configuration register file: weights, gains and sample period.
`default_nettype none

module lfs_regs
    import lfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output lfs_cfg_t    cfg
);

    lfs_cfg_t cfg_reg;
    lfs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (lfs_reg_idx_t'(cfg_index))
                REG_WEIGHT_0:   cfg_next.weight[0]  = cfg_data[15:0];
                REG_WEIGHT_1:   cfg_next.weight[1]  = cfg_data[15:0];
                REG_WEIGHT_2:   cfg_next.weight[2]  = cfg_data[15:0];
                REG_WEIGHT_3:   cfg_next.weight[3]  = cfg_data[15:0];
                REG_WEIGHT_4:   cfg_next.weight[4]  = cfg_data[15:0];
                REG_GAIN_PROP:  cfg_next.gain_prop  = cfg_data;
                REG_GAIN_DERIV: cfg_next.gain_deriv = cfg_data;
                REG_PERIOD:     cfg_next.period     = cfg_data[16:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight[0]  <= RST_WEIGHT_0;
            cfg_reg.weight[1]  <= RST_WEIGHT_1;
            cfg_reg.weight[2]  <= RST_WEIGHT_2;
            cfg_reg.weight[3]  <= RST_WEIGHT_3;
            cfg_reg.weight[4]  <= RST_WEIGHT_4;
            cfg_reg.gain_prop  <= RST_GAIN_PROP;
            cfg_reg.gain_deriv <= RST_GAIN_DERIV;
            cfg_reg.period     <= RST_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/lfs_seq.sv */
// Sequencer and datapath registers; drives the shared adder step by step.
`default_nettype none

module lfs_seq
    import lfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lfs_cfg_t         cfg,
    output lfs_alu_req_t     alu_req,
    input  logic [ALU_W-1:0] alu_y,
    lfs_item_if.sink         item,
    lfs_result_if.source     result
);

    // control state
    lfs_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    lfs_div_ph_t       divph_reg, divph_next;
    lfs_mul_ph_t       mulph_reg, mulph_next;
    logic              ovalid_reg, ovalid_next;
    logic [16:0]       time_reg, time_next;
    logic [15:0]       newer_reg, newer_next;
    logic [15:0]       older_reg, older_next;

    // payload
    logic              cmd_reg, cmd_next;
    logic [4:0]        sens_reg, sens_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [7:0]        maxs_reg, maxs_next;
    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [ALU_W-1:0]  mcand_reg, mcand_next;
    logic [MPLIER_W-1:0] mplier_reg, mplier_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic              pos_reg, pos_next;
    logic [15:0]       e_reg, e_next;
    logic signed [15:0] oerr_reg, oerr_next;
    logic [2:0]        odet_reg, odet_next;
    logic [1:0]        oblob_reg, oblob_next;
    logic signed [8:0] oleft_reg, oleft_next;
    logic signed [8:0] oright_reg, oright_next;

    // helpers
    logic [2:0]        lit;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  divisor;
    logic [CNT_W-1:0]  mul_len;
    logic              mul_signed;
    logic              mul_last;
    logic [15:0]       weight_sel;
    logic signed [39:0] q_trunc;
    logic signed [8:0] lowered;
    logic              raw_pos;

    function automatic logic [2:0] lit_count(input logic [4:0] s);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < 5; i++)
        begin
            c = c + 3'(s[i]);
        end
        return c;
    endfunction

    function automatic logic [1:0] run_count(input logic [4:0] s);
        logic [1:0] b;
        b = 2'(s[0]);
        for (int i = 1; i < 5; i++)
        begin
            if (!s[i-1] && s[i])
            begin
                b = b + 2'd1;
            end
        end
        return b;
    endfunction

    function automatic logic reverse_of(input logic signed [8:0] v);
        return v[8] || (v == 9'sd0);
    endfunction

    function automatic logic [7:0] duty_of(input logic signed [8:0] v);
        logic signed [8:0] m;
        m = v[8] ? -v : v;
        return m[7:0];
    endfunction

    assign lit = lit_count(sens_reg);
    assign shifted = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign raw_pos = !acc_reg[ALU_W-1] && (acc_reg != '0);

    // Divisor: lit count for the error, sample period (zero reads as one) for time.
    always_comb
    begin
        unique case (divph_reg)
            DIV_ERR:  divisor = DIV_W'(lit);
            DIV_TIME: divisor = (cfg.period == '0) ? DIV_W'(1) : DIV_W'(cfg.period);
            default:  divisor = DIV_W'(1);
        endcase
    end

    always_comb
    begin
        unique case (mulph_reg)
            MUL_X:   begin mul_len = CNT_W'(8);        mul_signed = 1'b0; end
            MUL_Y:   begin mul_len = CNT_W'(8);        mul_signed = 1'b0; end
            MUL_D:   begin mul_len = CNT_W'(MPLIER_W); mul_signed = 1'b1; end
            MUL_P:   begin mul_len = CNT_W'(16);       mul_signed = 1'b1; end
            MUL_R:   begin mul_len = CNT_W'(8);        mul_signed = 1'b0; end
            default: begin mul_len = CNT_W'(8);        mul_signed = 1'b0; end
        endcase
    end
    assign mul_last = (cnt_reg == mul_len - CNT_W'(1));

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0:    weight_sel = cfg.weight[0];
            3'd1:    weight_sel = cfg.weight[1];
            3'd2:    weight_sel = cfg.weight[2];
            3'd3:    weight_sel = cfg.weight[3];
            3'd4:    weight_sel = cfg.weight[4];
            default: weight_sel = '0;
        endcase
    end

    // offset / 2^24 truncated toward zero, then clamped to +-255
    assign q_trunc = $signed(acc_reg[ALU_W-1:FRAC_BITS])
                   + 40'(acc_reg[ALU_W-1] && (acc_reg[FRAC_BITS-1:0] != '0));
    always_comb
    begin
        priority if (q_trunc > 40'(SPEED_MAX))
        begin
            lowered = SPEED_MAX;
        end
        else if (q_trunc < 40'(SPEED_MIN))
        begin
            lowered = SPEED_MIN;
        end
        else
        begin
            lowered = q_trunc[8:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        divph_next   = divph_reg;
        mulph_next   = mulph_reg;
        ovalid_next  = ovalid_reg;
        time_next    = time_reg;
        newer_next   = newer_reg;
        older_next   = older_reg;
        cmd_next     = cmd_reg;
        sens_next    = sens_reg;
        elapsed_next = elapsed_reg;
        maxs_next    = maxs_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        pos_next     = pos_reg;
        e_next       = e_reg;
        oerr_next    = oerr_reg;
        odet_next    = odet_reg;
        oblob_next   = oblob_reg;
        oleft_next   = oleft_reg;
        oright_next  = oright_reg;
        alu_req.a    = acc_reg;
        alu_req.b    = '0;
        alu_req.sub  = 1'b0;
        item.ready   = 1'b0;

        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    cmd_next     = item.command;
                    sens_next    = item.sensors;
                    elapsed_next = item.elapsed_us;
                    maxs_next    = item.max_speed;
                    acc_next     = '0;
                    cnt_next     = '0;
                    state_next   = ST_SUM;
                end
            end

            // add the weights of the lit sensors, one sensor per cycle
            ST_SUM:
            begin
                alu_req.b = ALU_W'($signed(weight_sel));
                if (sens_reg[cnt_reg[2:0]])
                begin
                    acc_next = alu_y;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(4))
                begin
                    state_next = ST_ABS;
                end
            end

            ST_ABS:
            begin
                alu_req.a   = '0;
                alu_req.b   = acc_reg;
                alu_req.sub = acc_reg[ALU_W-1];
                quo_next    = alu_y[DIV_W-1:0];
                neg_next    = acc_reg[ALU_W-1];
                rem_next    = '0;
                cnt_next    = '0;
                divph_next  = DIV_ERR;
                state_next  = ST_DIV;
            end

            // restoring divide, one quotient bit per cycle
            ST_DIV:
            begin
                alu_req.a   = ALU_W'(shifted);
                alu_req.b   = ALU_W'(divisor);
                alu_req.sub = 1'b1;
                rem_next    = alu_y[ALU_W-1] ? shifted : alu_y[DIV_W-1:0];
                quo_next    = {quo_reg[DIV_W-2:0], !alu_y[ALU_W-1]};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = (divph_reg == DIV_ERR) ? ST_SIGN : ST_TFIN;
                end
            end

            ST_SIGN:
            begin
                alu_req.a   = '0;
                alu_req.b   = ALU_W'(quo_reg);
                alu_req.sub = neg_reg;
                e_next      = (lit == 3'd0) ? 16'd0 : alu_y[15:0];
                state_next  = (cmd_reg == CMD_TIME) ? ST_TADD : ST_X;
            end

            ST_TADD:
            begin
                alu_req.a  = ALU_W'(time_reg);
                alu_req.b  = ALU_W'(elapsed_reg);
                quo_next   = alu_y[DIV_W-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                divph_next = DIV_TIME;
                state_next = ST_DIV;
            end

            ST_TFIN:
            begin
                time_next = rem_reg[16:0];
                if (quo_reg[DIV_W-1:1] != '0)
                begin
                    older_next = e_reg;
                    newer_next = e_reg;
                end
                else if (quo_reg[0])
                begin
                    older_next = newer_reg;
                    newer_next = e_reg;
                end
                state_next = ST_IDLE;
            end

            ST_X:
            begin
                alu_req.a   = ALU_W'($signed(e_reg));
                alu_req.b   = ALU_W'($signed(newer_reg));
                alu_req.sub = 1'b1;
                mcand_next  = alu_y;
                mplier_next = D_COEF_NEWER;
                acc_next    = '0;
                cnt_next    = '0;
                mulph_next  = MUL_X;
                state_next  = ST_MUL;
            end

            ST_Y:
            begin
                alu_req.a   = ALU_W'($signed(e_reg));
                alu_req.b   = ALU_W'($signed(older_reg));
                alu_req.sub = 1'b1;
                mcand_next  = alu_y;
                mplier_next = D_COEF_OLDER;
                mulph_next  = MUL_Y;
                state_next  = ST_MUL;
            end

            ST_D:
            begin
                mplier_next = acc_reg[MPLIER_W-1:0];
                mcand_next  = ALU_W'($signed(cfg.gain_deriv));
                acc_next    = '0;
                mulph_next  = MUL_D;
                state_next  = ST_MUL;
            end

            ST_P:
            begin
                mplier_next = MPLIER_W'($signed(e_reg));
                mcand_next  = ALU_W'($signed(cfg.gain_prop));
                mulph_next  = MUL_P;
                state_next  = ST_MUL;
            end

            ST_R:
            begin
                mcand_next  = acc_reg;
                mplier_next = MPLIER_W'(maxs_reg);
                acc_next    = '0;
                mulph_next  = MUL_R;
                state_next  = ST_MUL;
            end

            // shift-add multiply; the sign bit of a signed multiplier subtracts
            ST_MUL:
            begin
                alu_req.b   = mcand_reg;
                alu_req.sub = mul_signed && mul_last;
                if (mplier_reg[0])
                begin
                    acc_next = alu_y;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (mul_last)
                begin
                    cnt_next = '0;
                    unique case (mulph_reg)
                        MUL_X:   state_next = ST_Y;
                        MUL_Y:   state_next = ST_D;
                        MUL_D:   state_next = ST_P;
                        MUL_P:   state_next = ST_R;
                        MUL_R:   state_next = ST_OFS;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_OFS:
            begin
                alu_req.a   = ALU_W'(maxs_reg) << FRAC_BITS;
                alu_req.b   = acc_reg;
                alu_req.sub = raw_pos;
                acc_next    = alu_y;
                pos_next    = raw_pos;
                state_next  = ST_OUT;
            end

            ST_OUT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    oerr_next   = e_reg;
                    odet_next   = lit;
                    oblob_next  = run_count(sens_reg);
                    if (pos_reg)
                    begin
                        oleft_next  = $signed({1'b0, maxs_reg});
                        oright_next = lowered;
                    end
                    else
                    begin
                        oleft_next  = lowered;
                        oright_next = $signed({1'b0, maxs_reg});
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            divph_reg  <= DIV_ERR;
            mulph_reg  <= MUL_X;
            ovalid_reg <= 1'b0;
            time_reg   <= '0;
            newer_reg  <= '0;
            older_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            divph_reg  <= divph_next;
            mulph_reg  <= mulph_next;
            ovalid_reg <= ovalid_next;
            time_reg   <= time_next;
            newer_reg  <= newer_next;
            older_reg  <= older_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        sens_reg    <= sens_next;
        elapsed_reg <= elapsed_next;
        maxs_reg    <= maxs_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        pos_reg     <= pos_next;
        e_reg       <= e_next;
        oerr_reg    <= oerr_next;
        odet_reg    <= odet_next;
        oblob_reg   <= oblob_next;
        oleft_reg   <= oleft_next;
        oright_reg  <= oright_next;
    end

    assign result.valid           = ovalid_reg;
    assign result.error_value     = oerr_reg;
    assign result.detection_count = odet_reg;
    assign result.blob_count      = oblob_reg;
    assign result.left_speed      = oleft_reg;
    assign result.right_speed     = oright_reg;
    assign result.left_reverse    = reverse_of(oleft_reg);
    assign result.left_duty       = duty_of(oleft_reg);
    assign result.right_reverse   = reverse_of(oright_reg);
    assign result.right_duty      = duty_of(oright_reg);

endmodule

`default_nettype wire

/* rtl/core/line_follow_pd_steering.sv */
// Line follower steering: weighted line error, error history timer and PD wheel speeds.
//
// One item is processed at a time; item.ready is high only while the sequencer is
// idle. The accumulation, divides, multiplies and offset all run on a single shared
// 64-bit add/subtract unit. The line error (weighted sum of lit sensors over their
// count, truncated toward zero) takes an accumulate step per sensor, a magnitude
// step, a restoring divide and a sign step. A time update (command 0) then adds
// elapsed_us to the timer and runs the same divider against the sample period;
// time updates yield no result. A speed request (command 1) forms the derivative
// and offset with five shift-add multiplies, each after its own setup step, then an
// offset step and an output step that loads the result register and returns the
// sequencer to idle. The result register holds the finished item, so the next item
// may be taken while it waits; a second speed result waits in its last step until
// the first has been taken.
// Configuration writes are taken at any time and must only be issued while idle.
`default_nettype none

module line_follow_pd_steering
    import lfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    lfs_item_if.sink         item,
    lfs_result_if.source     result
);

    lfs_cfg_t         cfg;      // current register values
    lfs_alu_req_t     alu_req;  // operands picked by the sequencer
    logic [ALU_W-1:0] alu_y;

    // weights, gains and sample period
    lfs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the one adder the accumulate, divide and multiply steps go through
    lfs_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    // state machine, working registers, history and the result register
    lfs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .alu_req (alu_req),
        .alu_y   (alu_y),
        .item    (item),
        .result  (result)
    );

endmodule

`default_nettype wire
